### src/csba_pkg.sv
`default_nettype none

package csba_pkg;

   // category count and field widths
   localparam int NUM_CAT = 7;
   localparam int CAT_W = 3;
   localparam int TICK_W = 64;
   localparam int WIDTH_W = 10;
   localparam int KIND_W = 3;

   // sum of all deltas, product of a delta and the width, shifted divisor
   localparam int TOTAL_W = TICK_W + CAT_W;
   localparam int PROD_W = TICK_W + WIDTH_W;
   localparam int QUO_W = 13;
   localparam int DIV_W = TOTAL_W + QUO_W - 1;
   localparam int STEP_W = 4;

   // bar width limits
   localparam int MIN_BAR_WIDTH = 10;
   localparam int MAX_BAR_WIDTH = 1000;

   typedef logic [TICK_W-1:0] tick_type;
   typedef logic [WIDTH_W-1:0] width_type;
   typedef logic [CAT_W-1:0] cat_type;
   typedef logic [KIND_W-1:0] kind_type;

   // counter categories in sample order
   localparam cat_type CAT_USER = 3'd0;
   localparam cat_type CAT_NICE = 3'd1;
   localparam cat_type CAT_SYSTEM = 3'd2;
   localparam cat_type CAT_IDLE = 3'd3;
   localparam cat_type CAT_IOWAIT = 3'd4;
   localparam cat_type CAT_IRQ = 3'd5;
   localparam cat_type CAT_SOFTIRQ = 3'd6;
   localparam cat_type CAT_LAST = CAT_SOFTIRQ;

   // segment kinds in output order
   localparam kind_type KIND_SYSTEM = 3'd0;
   localparam kind_type KIND_USER = 3'd1;
   localparam kind_type KIND_NICE = 3'd2;
   localparam kind_type KIND_IOWAIT = 3'd3;
   localparam kind_type KIND_IRQ = 3'd4;
   localparam kind_type KIND_SOFTIRQ = 3'd5;
   localparam kind_type KIND_IDLE = 3'd6;
   localparam kind_type KIND_UNKNOWN = 3'd7;

   // control from the front end to the sequencer
   typedef struct packed {
      logic start;
      logic sample_ok;
   } core_ctl_type;

   // category shown by each segment kind
   function automatic cat_type seg_cat(input kind_type kind);
      cat_type cat;
      case (kind)
         KIND_SYSTEM: cat = CAT_SYSTEM;
         KIND_USER: cat = CAT_USER;
         KIND_NICE: cat = CAT_NICE;
         KIND_IOWAIT: cat = CAT_IOWAIT;
         KIND_IRQ: cat = CAT_IRQ;
         KIND_SOFTIRQ: cat = CAT_SOFTIRQ;
         default: cat = CAT_IDLE;
      endcase
      return cat;
   endfunction

endpackage

`default_nettype wire

### src/csba_divider.sv
`default_nettype none

module csba_divider import csba_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [PROD_W-1:0]   dividend,
   input  wire logic [TOTAL_W-1:0]  divisor,
   output logic                     done,
   output logic [QUO_W-1:0]         quotient,
   output logic [TOTAL_W-1:0]       remainder
);

   logic [PROD_W-1:0] rem_ff;
   logic [DIV_W-1:0] dv_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [STEP_W-1:0] step_ff;
   logic busy_ff;
   logic done_ff;
   logic fits;
   logic [PROD_W-1:0] diff;

   // one restoring step: compare against the shifted divisor
   assign fits = {{(DIV_W-PROD_W){1'b0}}, rem_ff} >= dv_ff;
   assign diff = rem_ff - dv_ff[PROD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= busy_ff && (step_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(QUO_W - 1);
         end else if (busy_ff) begin
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
            end else begin
               step_ff <= step_ff - 1'b1;
            end
         end
      end
   end

   // quotient bits come out msb first
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend;
         dv_ff <= {divisor, {(QUO_W-1){1'b0}}};
         quo_ff <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= diff;
         end
         quo_ff <= {quo_ff[QUO_W-2:0], fits};
         dv_ff <= dv_ff >> 1;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff[TOTAL_W-1:0];

endmodule

`default_nettype wire

### src/csba_core.sv
`default_nettype none

module csba_core import csba_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire core_ctl_type  ctl,
   input  wire width_type     width,
   input  wire tick_type      delta,
   output logic               idle,
   output cat_type            delta_sel,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output kind_type           rsp_segment_kind,
   output width_type          rsp_segment_length,
   output logic               rsp_segment_last
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_MUL,
      ST_DIV,
      ST_PIVOT,
      ST_RANK,
      ST_EMIT
   } state_type;

   state_type state_ff;
   cat_type idx_ff;
   cat_type piv_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] pivot_ff;
   width_type qsum_ff;
   width_type q_ff [NUM_CAT];
   logic [TOTAL_W-1:0] rem_ff [NUM_CAT];
   cat_type rank_ff [NUM_CAT];
   logic rsp_valid_ff;
   kind_type rsp_kind_ff;
   width_type rsp_len_ff;
   logic rsp_last_ff;

   logic [TOTAL_W-1:0] total_in;
   logic [PROD_W-1:0] product;
   logic div_done;
   logic [QUO_W-1:0] div_quo;
   logic [TOTAL_W-1:0] div_rem;
   cat_type rd_sel;
   logic [TOTAL_W-1:0] rem_rd;
   logic pivot_loses;
   cat_type loser;
   width_type extra;
   kind_type emit_kind_in;
   cat_type emit_cat;
   width_type emit_len;
   logic hand;

   // running total of the deltas
   assign total_in = total_ff + TOTAL_W'(delta);

   // delta times width, registered inside the divider on start
   assign product = PROD_W'(delta) * PROD_W'(width);

   csba_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (state_ff == ST_MUL),
      .dividend  (product),
      .divisor   (total_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // one read port on the remainders: pivot load or compare
   assign rd_sel = (state_ff == ST_PIVOT) ? piv_ff : idx_ff;
   assign rem_rd = rem_ff[rd_sel];

   // pair compare, a tie goes to the lower index (the pivot)
   // the side ranked behind counts one more category ahead of it
   assign pivot_loses = rem_rd > pivot_ff;
   assign loser = pivot_loses ? piv_ff : idx_ff;

   // cells still missing after the floor shares
   assign extra = width - qsum_ff;

   // next segment to show
   assign emit_kind_in = (state_ff == ST_EMIT) ? rsp_kind_ff + 1'b1 : KIND_SYSTEM;
   assign emit_cat = seg_cat(emit_kind_in);
   assign emit_len = (WIDTH_W'(rank_ff[emit_cat]) < extra) ? q_ff[emit_cat] + 1'b1
                                                           : q_ff[emit_cat];

   assign hand = rsp_valid_ff && !rsp_stall;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
         piv_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (ctl.start) begin
                  total_ff <= '0;
                  qsum_ff <= '0;
                  idx_ff <= '0;
                  for (int j = 0; j < NUM_CAT; j++) begin
                     rank_ff[j] <= '0;
                  end
                  if (ctl.sample_ok) begin
                     state_ff <= ST_SUM;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                     rsp_kind_ff <= KIND_UNKNOWN;
                     rsp_len_ff <= width;
                     rsp_last_ff <= 1'b1;
                     state_ff <= ST_EMIT;
                  end
               end
            end
            ST_SUM: begin
               total_ff <= total_in;
               if (idx_ff == CAT_LAST) begin
                  idx_ff <= '0;
                  if (total_in == '0) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_kind_ff <= KIND_UNKNOWN;
                     rsp_len_ff <= width;
                     rsp_last_ff <= 1'b1;
                     state_ff <= ST_EMIT;
                  end else begin
                     state_ff <= ST_MUL;
                  end
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_MUL: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (div_done) begin
                  q_ff[idx_ff] <= div_quo[WIDTH_W-1:0];
                  rem_ff[idx_ff] <= div_rem;
                  qsum_ff <= qsum_ff + div_quo[WIDTH_W-1:0];
                  if (idx_ff == CAT_LAST) begin
                     piv_ff <= '0;
                     state_ff <= ST_PIVOT;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                     state_ff <= ST_MUL;
                  end
               end
            end
            ST_PIVOT: begin
               pivot_ff <= rem_rd;
               idx_ff <= piv_ff + 1'b1;
               state_ff <= ST_RANK;
            end
            ST_RANK: begin
               for (int j = 0; j < NUM_CAT; j++) begin
                  if (loser == CAT_W'(j)) begin
                     rank_ff[j] <= rank_ff[j] + 1'b1;
                  end
               end
               if (idx_ff == CAT_LAST) begin
                  if (piv_ff == CAT_LAST - 1'b1) begin
                     // last pair does not touch the system rank shown first
                     rsp_valid_ff <= 1'b1;
                     rsp_kind_ff <= emit_kind_in;
                     rsp_len_ff <= emit_len;
                     rsp_last_ff <= 1'b0;
                     state_ff <= ST_EMIT;
                  end else begin
                     piv_ff <= piv_ff + 1'b1;
                     state_ff <= ST_PIVOT;
                  end
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_EMIT: begin
               if (hand) begin
                  if (rsp_last_ff) begin
                     rsp_valid_ff <= 1'b0;
                     state_ff <= ST_IDLE;
                  end else begin
                     rsp_kind_ff <= emit_kind_in;
                     rsp_len_ff <= emit_len;
                     rsp_last_ff <= (emit_kind_in == KIND_IDLE);
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign idle = (state_ff == ST_IDLE);
   assign delta_sel = idx_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_segment_kind = rsp_kind_ff;
   assign rsp_segment_length = rsp_len_ff;
   assign rsp_segment_last = rsp_last_ff;

endmodule

`default_nettype wire

### src/cpu_share_bar_apportion_top.sv
// a valid sample with nonzero total runs to its last segment through 7 summing steps,
// 7 divisions on the shared restoring divider, pairwise remainder ranking and 7 segments,
// and an output stall can hold each segment
// a zero total gives its one segment after the summing steps, a failed read straight from idle
// throughput: one sample at a time, the next is taken the cycle after the last segment
// reset (synchronous, active high) clears the stored counters and sets the width to 10
`default_nettype none

module cpu_share_bar_apportion_top import csba_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_sample_ok,
   input  wire tick_type   req_user_ticks,
   input  wire tick_type   req_nice_ticks,
   input  wire tick_type   req_system_ticks,
   input  wire tick_type   req_idle_ticks,
   input  wire tick_type   req_iowait_ticks,
   input  wire tick_type   req_irq_ticks,
   input  wire tick_type   req_softirq_ticks,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output kind_type        rsp_segment_kind,
   output width_type       rsp_segment_length,
   output logic            rsp_segment_last,
   input  wire logic       csr_wr_en,
   input  wire width_type  csr_wr_data
);

   width_type bar_width_ff;
   width_type width_eff;
   tick_type prev_ff [NUM_CAT];
   tick_type delta_ff [NUM_CAT];
   tick_type now [NUM_CAT];
   tick_type delta_rd;
   cat_type delta_sel;
   logic core_idle;
   logic accept;
   core_ctl_type core_ctl;

   // width register
   always_ff @(posedge clock) begin
      if (reset) begin
         bar_width_ff <= WIDTH_W'(MIN_BAR_WIDTH);
      end else if (csr_wr_en) begin
         bar_width_ff <= csr_wr_data;
      end
   end

   // saturate the width to the supported range
   always_comb begin
      if (bar_width_ff < WIDTH_W'(MIN_BAR_WIDTH)) begin
         width_eff = WIDTH_W'(MIN_BAR_WIDTH);
      end else if (bar_width_ff > WIDTH_W'(MAX_BAR_WIDTH)) begin
         width_eff = WIDTH_W'(MAX_BAR_WIDTH);
      end else begin
         width_eff = bar_width_ff;
      end
   end

   // sample fields in category order
   assign now[CAT_USER] = req_user_ticks;
   assign now[CAT_NICE] = req_nice_ticks;
   assign now[CAT_SYSTEM] = req_system_ticks;
   assign now[CAT_IDLE] = req_idle_ticks;
   assign now[CAT_IOWAIT] = req_iowait_ticks;
   assign now[CAT_IRQ] = req_irq_ticks;
   assign now[CAT_SOFTIRQ] = req_softirq_ticks;

   assign req_stall = !core_idle;
   assign accept = req_valid && !req_stall;

   // deltas clamp at zero, stored counters follow a good sample
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CAT; i++) begin
            prev_ff[i] <= '0;
         end
      end else if (accept && req_sample_ok) begin
         for (int i = 0; i < NUM_CAT; i++) begin
            prev_ff[i] <= now[i];
            delta_ff[i] <= (now[i] >= prev_ff[i]) ? now[i] - prev_ff[i] : '0;
         end
      end
   end

   assign delta_rd = delta_ff[delta_sel];

   assign core_ctl.start = accept;
   assign core_ctl.sample_ok = req_sample_ok;

   csba_core u_core (
      .clock              (clock),
      .reset              (reset),
      .ctl                (core_ctl),
      .width              (width_eff),
      .delta              (delta_rd),
      .idle               (core_idle),
      .delta_sel          (delta_sel),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_segment_kind   (rsp_segment_kind),
      .rsp_segment_length (rsp_segment_length),
      .rsp_segment_last   (rsp_segment_last)
   );

   // no new item while segments are pending
   a_busy_while_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a segment is pending");

   // an accepted item closes the input on the next cycle
   a_close_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input still open after an accepted item");

   // the question mark segment stands alone
   a_unknown_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_segment_kind == KIND_UNKNOWN) |-> rsp_segment_last)
      else $error("question mark segment not marked last");

   // only the idle fill or the question mark ends a sample
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_segment_last) |->
         (rsp_segment_kind == KIND_IDLE || rsp_segment_kind == KIND_UNKNOWN))
      else $error("last segment of wrong kind");

endmodule

`default_nettype wire

### tb/sv/cpu_share_bar_apportion_top_tb.sv
`timescale 1ns / 1ps

module cpu_share_bar_apportion_top_tb;
   import csba_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_PHASES = 4;
   localparam int ITEMS_PER_PHASE = 35;

   // segment order on the bar and the category each one shows
   localparam kind_type SEG_KIND[NUM_CAT] = '{KIND_SYSTEM, KIND_USER, KIND_NICE,
      KIND_IOWAIT, KIND_IRQ, KIND_SOFTIRQ, KIND_IDLE};
   localparam cat_type SEG_SOURCE[NUM_CAT] = '{CAT_SYSTEM, CAT_USER, CAT_NICE,
      CAT_IOWAIT, CAT_IRQ, CAT_SOFTIRQ, CAT_IDLE};

   typedef struct packed {
      logic ok;
      tick_type [NUM_CAT-1:0] ticks;
   } sample_t;

   typedef struct packed {
      kind_type kind;
      width_type length;
      logic last;
   } segment_t;

   // predicts the bar segments of each sample and checks them in order
   class segment_scoreboard;
      tick_type stored[NUM_CAT];
      width_type width_reg;
      segment_t expected_segments[$];
      int errors;

      function new();
         foreach (stored[c]) stored[c] = '0;
         width_reg = width_type'(MIN_BAR_WIDTH);
         errors = 0;
      endfunction

      function void set_width(width_type w);
         width_reg = w;
      endfunction

      function int pending();
         return expected_segments.size();
      endfunction

      function void push_unknown(int cells);
         segment_t seg;
         seg.kind = KIND_UNKNOWN;
         seg.length = width_type'(cells);
         seg.last = 1'b1;
         expected_segments.push_back(seg);
      endfunction

      function void take_sample(sample_t s);
         tick_type delta[NUM_CAT];
         logic [TOTAL_W-1:0] total;
         logic [PROD_W-1:0] prod;
         logic [TOTAL_W-1:0] rem[NUM_CAT];
         int cells[NUM_CAT];
         bit granted[NUM_CAT];
         int bar_cells;
         int used_cells;
         int pick;
         segment_t seg;

         bar_cells = int'(width_reg);
         if (bar_cells < MIN_BAR_WIDTH) bar_cells = MIN_BAR_WIDTH;
         if (bar_cells > MAX_BAR_WIDTH) bar_cells = MAX_BAR_WIDTH;
         // failed read leaves the stored counters alone
         if (!s.ok) begin
            push_unknown(bar_cells);
            return;
         end
         // deltas, clamped at zero when a counter went backwards
         total = '0;
         for (int c = 0; c < NUM_CAT; c++) begin
            delta[c] = (s.ticks[c] < stored[c]) ? '0 : s.ticks[c] - stored[c];
            stored[c] = s.ticks[c];
            total += TOTAL_W'(delta[c]);
         end
         if (total == '0) begin
            push_unknown(bar_cells);
            return;
         end
         // exact floor share and remainder per category
         used_cells = 0;
         for (int c = 0; c < NUM_CAT; c++) begin
            prod = PROD_W'(delta[c]) * PROD_W'(bar_cells);
            cells[c] = int'(prod / PROD_W'(total));
            rem[c] = TOTAL_W'(prod % PROD_W'(total));
            granted[c] = 1'b0;
            used_cells += cells[c];
         end
         // missing cells go to the largest remainders, lowest index on ties
         while (used_cells < bar_cells) begin
            pick = -1;
            for (int c = 0; c < NUM_CAT; c++) begin
               if (!granted[c] && (pick < 0 || rem[c] > rem[pick])) pick = c;
            end
            if (pick < 0) break;
            granted[pick] = 1'b1;
            cells[pick]++;
            used_cells++;
         end
         for (int k = 0; k < NUM_CAT; k++) begin
            seg.kind = SEG_KIND[k];
            seg.length = width_type'(cells[SEG_SOURCE[k]]);
            seg.last = (k == NUM_CAT - 1);
            expected_segments.push_back(seg);
         end
      endfunction

      function void check_segment(kind_type kind, width_type length, logic last);
         segment_t want;
         if (expected_segments.size() == 0) begin
            $error("unexpected segment: kind %0d length %0d last %0d", kind, length, last);
            errors++;
            return;
         end
         want = expected_segments.pop_front();
         if (kind !== want.kind) begin
            $error("segment_kind: expected %0d, actual %0d", want.kind, kind);
            errors++;
         end
         if (length !== want.length) begin
            $error("segment_length: expected %0d, actual %0d", want.length, length);
            errors++;
         end
         if (last !== want.last) begin
            $error("segment_last: expected %0d, actual %0d", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_sample_ok;
   tick_type req_user_ticks;
   tick_type req_nice_ticks;
   tick_type req_system_ticks;
   tick_type req_idle_ticks;
   tick_type req_iowait_ticks;
   tick_type req_irq_ticks;
   tick_type req_softirq_ticks;
   logic rsp_valid;
   logic rsp_stall;
   kind_type rsp_segment_kind;
   width_type rsp_segment_length;
   logic rsp_segment_last;
   logic csr_wr_en;
   width_type csr_wr_data;

   segment_scoreboard sb = new();
   tick_type cur[NUM_CAT];
   int send_idle_pct = 29;
   int rsp_idle_pct = 29;
   int holds_asked = 0;
   int holds_done = 0;
   int hold_left = 0;
   int cycle_count = 0;

   cpu_share_bar_apportion_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample_ok(req_sample_ok),
      .req_user_ticks(req_user_ticks),
      .req_nice_ticks(req_nice_ticks),
      .req_system_ticks(req_system_ticks),
      .req_idle_ticks(req_idle_ticks),
      .req_iowait_ticks(req_iowait_ticks),
      .req_irq_ticks(req_irq_ticks),
      .req_softirq_ticks(req_softirq_ticks),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_segment_kind(rsp_segment_kind),
      .rsp_segment_length(rsp_segment_length),
      .rsp_segment_last(rsp_segment_last),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("cpu_share_bar_apportion_top regression: fail");
         $finish;
      end
   end

   // receiver stall: random, or a long hold when one is asked for
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (holds_done < holds_asked) begin
         holds_done++;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   // segment check
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_segment(rsp_segment_kind, rsp_segment_length, rsp_segment_last);
   end

   function automatic sample_t pack_counters(logic ok);
      sample_t s;
      s.ok = ok;
      for (int c = 0; c < NUM_CAT; c++) s.ticks[c] = cur[c];
      return s;
   endfunction

   task automatic set_all(tick_type v);
      foreach (cur[c]) cur[c] = v;
   endtask

   // offer one item, with random gaps before it
   task automatic send_sample(sample_t s);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample_ok <= s.ok;
      req_user_ticks <= s.ticks[CAT_USER];
      req_nice_ticks <= s.ticks[CAT_NICE];
      req_system_ticks <= s.ticks[CAT_SYSTEM];
      req_idle_ticks <= s.ticks[CAT_IDLE];
      req_iowait_ticks <= s.ticks[CAT_IOWAIT];
      req_irq_ticks <= s.ticks[CAT_IRQ];
      req_softirq_ticks <= s.ticks[CAT_SOFTIRQ];
      do @(posedge clock); while (req_stall);
      sb.take_sample(s);
   endtask

   // stop offering and wait until every segment has come out
   task automatic wait_for_segments();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0 || hold_left > 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_width(width_type w);
      wait_for_segments();
      csr_wr_en <= 1'b1;
      csr_wr_data <= w;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.set_width(w);
   endtask

   initial begin
      sample_t s;
      int mode;
      int phase_width;
      tick_type inc;

      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_ok = 1'b0;
      req_user_ticks = '0;
      req_nice_ticks = '0;
      req_system_ticks = '0;
      req_idle_ticks = '0;
      req_iowait_ticks = '0;
      req_irq_ticks = '0;
      req_softirq_ticks = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      set_all('0);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // failed read with all ones, stored counters stay zero
      set_all('1);
      send_sample(pack_counters(1'b0));
      // zero total
      set_all('0);
      send_sample(pack_counters(1'b1));
      // huge equal deltas, total wider than 64 bits, ties on every remainder
      set_all('1);
      send_sample(pack_counters(1'b1));
      // failed read, then every counter goes backwards
      set_all('0);
      send_sample(pack_counters(1'b0));
      send_sample(pack_counters(1'b1));
      // one category alone takes the whole bar
      for (int c = 0; c < NUM_CAT; c++) begin
         cur[c] += tick_type'(1000 + c);
         send_sample(pack_counters(1'b1));
      end
      // small equal deltas
      foreach (cur[c]) cur[c] += 1;
      send_sample(pack_counters(1'b1));

      write_width(width_type'(MAX_BAR_WIDTH));
      cur[CAT_USER] += 3;
      cur[CAT_SYSTEM] += 1;
      cur[CAT_IDLE] += 5;
      cur[CAT_IRQ] += 2;
      send_sample(pack_counters(1'b1));
      repeat (2) begin
         foreach (cur[c]) cur[c] = {$urandom, $urandom};
         send_sample(pack_counters(1'b1));
      end

      // widths out of range
      write_width('0);
      foreach (cur[c]) cur[c] += tick_type'(c + 1);
      send_sample(pack_counters(1'b1));
      write_width('1);
      foreach (cur[c]) cur[c] += tick_type'(3 * c + 2);
      send_sample(pack_counters(1'b1));
      write_width(width_type'(MIN_BAR_WIDTH - 1));
      foreach (cur[c]) cur[c] += tick_type'($urandom_range(0, 50));
      send_sample(pack_counters(1'b1));

      // random phases at several widths
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: phase_width = $urandom_range(MIN_BAR_WIDTH, MAX_BAR_WIDTH);
            1: phase_width = MAX_BAR_WIDTH;
            2: phase_width = MIN_BAR_WIDTH;
            default: phase_width = $urandom_range(0, 1023);
         endcase
         write_width(width_type'(phase_width));
         // no idling in the second phase, a long receiver hold in the third
         send_idle_pct = (phase == 1 || phase == 2) ? 0 : 29;
         rsp_idle_pct = (phase == 1) ? 0 : 29;
         if (phase == 2) holds_asked++;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            mode = $urandom_range(0, 99);
            if (mode < 8) begin
               // failed read with noise
               foreach (s.ticks[c]) s.ticks[c] = {$urandom, $urandom};
               s.ok = 1'b0;
            end else begin
               if (mode < 13) begin
                  // repeated sample, zero total
               end else if (mode < 20) begin
                  foreach (cur[c]) cur[c] = {$urandom, $urandom};
               end else if (mode < 26) begin
                  foreach (cur[c])
                     if ($urandom_range(0, 1)) cur[c] -= tick_type'($urandom_range(0, 1000));
               end else begin
                  foreach (cur[c]) begin
                     case ($urandom_range(0, 3))
                        0: inc = tick_type'($urandom_range(0, 9));
                        1: inc = tick_type'($urandom_range(0, 100));
                        2: inc = tick_type'($urandom);
                        default: inc = {$urandom, $urandom} >> $urandom_range(0, 63);
                     endcase
                     cur[c] += inc;
                  end
               end
               s = pack_counters(1'b1);
            end
            send_sample(s);
         end
      end

      send_idle_pct = 29;
      rsp_idle_pct = 29;
      wait_for_segments();
      repeat (200) @(posedge clock);
      if (sb.errors == 0)
         $display("cpu_share_bar_apportion_top regression: pass");
      else
         $display("cpu_share_bar_apportion_top regression: fail");
      $finish;
   end

endmodule

### files.f
src/csba_pkg.sv
src/csba_divider.sv
src/csba_core.sv
src/cpu_share_bar_apportion_top.sv
tb/sv/cpu_share_bar_apportion_top_tb.sv
